[sv/thmt_pkg.sv]
`timescale 1ns / 1ps
// Shared types, codes and CRC helper for the two-way hashed exact-match table.
// Used by thmt_hash_pipe and two_way_hashed_exact_match_table_core.
package thmt_pkg;

  localparam int KEY_FIELD_W    = 64;
  localparam int HANDLE_FIELD_W = 16;
  localparam int TOTAL_W        = 12;
  localparam int CRC_W          = 32;
  localparam int STEP_BITS      = 8;
  localparam int HASH_STAGES    = KEY_FIELD_W / STEP_BITS;

  localparam int DEF_KEY_WIDTH    = 64;
  localparam int DEF_LOG_BUCKETS  = 10;
  localparam int DEF_HANDLE_WIDTH = 16;

  localparam logic [31:0] POLY0_RESET = 32'h04C1_1DB7;
  localparam logic [31:0] POLY1_RESET = 32'h1EDC_6F41;
  localparam logic [3:0]  LG_RESET    = 4'd10;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2,
    ST_WILD = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    REG_POLY0 = 2'd0,
    REG_POLY1 = 2'd1,
    REG_LG0   = 2'd2,
    REG_LG1   = 2'd3
  } reg_e;

  typedef struct packed {
    logic [1:0]                op;
    logic [KEY_FIELD_W-1:0]    flow_key;
    logic                      has_wildcards;
    logic [HANDLE_FIELD_W-1:0] flow_handle;
  } item_t;

  typedef struct packed {
    logic [1:0]                status;
    logic                      hit_table;
    logic [HANDLE_FIELD_W-1:0] found_handle;
    logic [1:0]                deleted_count;
    logic [TOTAL_W-1:0]        flow_total;
  } result_t;

  function automatic logic [CRC_W-1:0] crc_step(input logic [CRC_W-1:0] crc,
                                                input logic [STEP_BITS-1:0] data,
                                                input logic [CRC_W-1:0] poly);
    logic [CRC_W-1:0] c;
    logic             top;
    c = crc;
    for (int i = STEP_BITS - 1; i >= 0; i--) begin
      top = c[CRC_W-1] ^ data[i];
      c   = {c[CRC_W-2:0], 1'b0};
      if (top) begin
        c = c ^ poly;
      end
    end
    return c;
  endfunction

endpackage

[sv/thmt_hash_pipe.sv]
`timescale 1ns / 1ps
// Pipelined 32-bit CRC (zero initial value, no reflection) of the key under two polynomials, one key byte per stage.
// Depends on thmt_pkg.
module thmt_hash_pipe (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  thmt_pkg::item_t             item_i,
  input  logic [thmt_pkg::CRC_W-1:0]  poly0_i,
  input  logic [thmt_pkg::CRC_W-1:0]  poly1_i,
  output logic                        valid_o,
  output thmt_pkg::item_t             item_o,
  output logic [thmt_pkg::CRC_W-1:0]  crc0_o,
  output logic [thmt_pkg::CRC_W-1:0]  crc1_o
);
  import thmt_pkg::*;

  logic [HASH_STAGES-1:0] vld_q;
  item_t                  itm_q [HASH_STAGES];
  logic [CRC_W-1:0]       c0_q  [HASH_STAGES];
  logic [CRC_W-1:0]       c1_q  [HASH_STAGES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[HASH_STAGES-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      itm_q[0] <= item_i;
      c0_q[0]  <= crc_step('0, item_i.flow_key[KEY_FIELD_W-1 -: STEP_BITS], poly0_i);
      c1_q[0]  <= crc_step('0, item_i.flow_key[KEY_FIELD_W-1 -: STEP_BITS], poly1_i);
      for (int s = 1; s < HASH_STAGES; s++) begin
        itm_q[s] <= itm_q[s-1];
        c0_q[s]  <= crc_step(c0_q[s-1],
                             itm_q[s-1].flow_key[KEY_FIELD_W-1-STEP_BITS*s -: STEP_BITS],
                             poly0_i);
        c1_q[s]  <= crc_step(c1_q[s-1],
                             itm_q[s-1].flow_key[KEY_FIELD_W-1-STEP_BITS*s -: STEP_BITS],
                             poly1_i);
      end
    end
  end

  assign valid_o = vld_q[HASH_STAGES-1];
  assign item_o  = itm_q[HASH_STAGES-1];
  assign crc0_o  = c0_q[HASH_STAGES-1];
  assign crc1_o  = c1_q[HASH_STAGES-1];

endmodule

[sv/two_way_hashed_exact_match_table_core.sv]
`timescale 1ns / 1ps
// Top level of the two-way hashed exact-match flow table.
// Depends on thmt_pkg and thmt_hash_pipe.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) takes one word: op, flow key,
//   wildcard flag and handle. Output channel (out_valid_o/out_ready_i)
//   returns one result word per input word, in order.
//   Registers are written over the APB port (polynomials, log2 bucket counts);
//   the user must write them only while the table is idle; the block does not enforce it.
// Pipeline:
//   A word is accepted per cycle while in_ready_o is high. Its result passes
//   8 hash stages (one key byte each), one bucket read stage and one
//   compare/update stage, whose result goes into a 2-entry output queue.
//   The single read-then-write of each bucket memory sets the one-cycle rate;
//   a write to the same bucket is forwarded to the following word.
// Reset:
//   After reset a clearing pass zeroes both bucket memories, one bucket a
//   cycle, over all 2**LOG_BUCKETS buckets (1024 by default); in_ready_o stays low.
// Stall:
//   When out_ready_i is low the queue holds up to two results; once full the
//   whole pipeline holds and in_ready_o drops.
module two_way_hashed_exact_match_table_core #(
  parameter int KEY_WIDTH    = thmt_pkg::DEF_KEY_WIDTH,
  parameter int LOG_BUCKETS  = thmt_pkg::DEF_LOG_BUCKETS,
  parameter int HANDLE_WIDTH = thmt_pkg::DEF_HANDLE_WIDTH
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [1:0]                          op_i,
  input  logic [thmt_pkg::KEY_FIELD_W-1:0]    flow_key_i,
  input  logic                                has_wildcards_i,
  input  logic [thmt_pkg::HANDLE_FIELD_W-1:0] flow_handle_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [1:0]                          status_o,
  output logic                                hit_table_o,
  output logic [thmt_pkg::HANDLE_FIELD_W-1:0] found_handle_o,
  output logic [1:0]                          deleted_count_o,
  output logic [thmt_pkg::TOTAL_W-1:0]        flow_total_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [3:0]                          paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);
  import thmt_pkg::*;

  localparam int DEPTH = 1 << LOG_BUCKETS;
  localparam int EW    = 1 + KEY_WIDTH + HANDLE_WIDTH;
  localparam int CW    = LOG_BUCKETS + 2;
  localparam int LGW   = 5;

  // configuration
  logic [31:0] poly0_q, poly1_q;
  logic [3:0]  lg0_q, lg1_q;
  logic        cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poly0_q <= POLY0_RESET;
      poly1_q <= POLY1_RESET;
      lg0_q   <= LG_RESET;
      lg1_q   <= LG_RESET;
    end else if (cfg_we) begin
      unique case (reg_e'(paddr[3:2]))
        REG_POLY0: poly0_q <= pwdata;
        REG_POLY1: poly1_q <= pwdata;
        REG_LG0:   lg0_q   <= pwdata[3:0];
        REG_LG1:   lg1_q   <= pwdata[3:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_e'(paddr[3:2]))
      REG_POLY0: prdata = poly0_q;
      REG_POLY1: prdata = poly1_q;
      REG_LG0:   prdata = {28'd0, lg0_q};
      REG_LG1:   prdata = {28'd0, lg1_q};
      default:   prdata = '0;
    endcase
  end

  // pipeline control
  logic [1:0] fq_cnt_q;
  logic       en;
  logic       clr_q;
  logic [LOG_BUCKETS-1:0] clr_addr_q;

  assign en         = (fq_cnt_q != 2'd2);
  assign in_ready_o = en & ~clr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_q) begin
      clr_addr_q <= clr_addr_q + LOG_BUCKETS'(1);
      if (&clr_addr_q) begin
        clr_q <= 1'b0;
      end
    end
  end

  // hash stages
  item_t       item_in, item_a;
  logic        vld_a;
  logic [31:0] crc0_a, crc1_a;

  always_comb begin
    item_in               = '0;
    item_in.op            = op_i;
    item_in.flow_key      = KEY_FIELD_W'(flow_key_i[KEY_WIDTH-1:0]);
    item_in.has_wildcards = has_wildcards_i;
    item_in.flow_handle   = flow_handle_i;
  end

  thmt_hash_pipe u_hash (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i & in_ready_o),
    .item_i  (item_in),
    .poly0_i (poly0_q),
    .poly1_i (poly1_q),
    .valid_o (vld_a),
    .item_o  (item_a),
    .crc0_o  (crc0_a),
    .crc1_o  (crc1_a)
  );

  // bucket select
  logic [LGW-1:0]         lge0, lge1;
  logic [LOG_BUCKETS-1:0] mask0, mask1, addr0_a, addr1_a;

  always_comb begin
    lge0 = ({1'b0, lg0_q} > LGW'(LOG_BUCKETS)) ? LGW'(LOG_BUCKETS) : {1'b0, lg0_q};
    lge1 = ({1'b0, lg1_q} > LGW'(LOG_BUCKETS)) ? LGW'(LOG_BUCKETS) : {1'b0, lg1_q};
    for (int i = 0; i < LOG_BUCKETS; i++) begin
      mask0[i] = (LGW'(i) < lge0);
      mask1[i] = (LGW'(i) < lge1);
    end
    addr0_a = crc0_a[LOG_BUCKETS-1:0] & mask0;
    addr1_a = crc1_a[LOG_BUCKETS-1:0] & mask1;
  end

  // bucket memories
  logic [EW-1:0]          mem0 [DEPTH];
  logic [EW-1:0]          mem1 [DEPTH];
  logic [EW-1:0]          rd0_q, rd1_q, wd0, wd1, nd0, nd1;
  logic                   we0, we1, w0, w1;
  logic [LOG_BUCKETS-1:0] wa0, wa1;

  logic                   vld_b_q;
  item_t                  item_b_q;
  logic [LOG_BUCKETS-1:0] addr0_b_q, addr1_b_q;

  always_ff @(posedge clk_i) begin
    if (we0) begin
      mem0[wa0] <= wd0;
    end
    if (we1) begin
      mem1[wa1] <= wd1;
    end
    if (en) begin
      rd0_q     <= (we0 && wa0 == addr0_a) ? wd0 : mem0[addr0_a];
      rd1_q     <= (we1 && wa1 == addr1_a) ? wd1 : mem1[addr1_a];
      item_b_q  <= item_a;
      addr0_b_q <= addr0_a;
      addr1_b_q <= addr1_a;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_b_q <= 1'b0;
    end else if (en) begin
      vld_b_q <= vld_a;
    end
  end

  // compare and update
  logic                    v0, v1, h0, h1, eq0, eq1;
  logic [KEY_WIDTH-1:0]    key_b;
  logic [HANDLE_WIDTH-1:0] hdl_b, hd0, hd1;
  logic [CW-1:0]           cnt_q, cnt_d;
  result_t                 res;

  always_comb begin
    key_b = item_b_q.flow_key[KEY_WIDTH-1:0];
    hdl_b = HANDLE_WIDTH'(item_b_q.flow_handle);
    v0    = rd0_q[EW-1];
    v1    = rd1_q[EW-1];
    eq0   = (rd0_q[EW-2 -: KEY_WIDTH] == key_b);
    eq1   = (rd1_q[EW-2 -: KEY_WIDTH] == key_b);
    hd0   = rd0_q[HANDLE_WIDTH-1:0];
    hd1   = rd1_q[HANDLE_WIDTH-1:0];
    h0    = v0 & eq0;
    h1    = v1 & eq1;
    w0    = 1'b0;
    w1    = 1'b0;
    nd0   = {1'b1, key_b, hdl_b};
    nd1   = {1'b1, key_b, hdl_b};
    cnt_d = cnt_q;
    res   = '0;
    res.status = ST_MISS;
    unique case (item_b_q.op)
      OP_LOOKUP: begin
        if (!item_b_q.has_wildcards) begin
          if (h0) begin
            res.status       = ST_OK;
            res.found_handle = HANDLE_FIELD_W'(hd0);
          end else if (h1) begin
            res.status       = ST_OK;
            res.hit_table    = 1'b1;
            res.found_handle = HANDLE_FIELD_W'(hd1);
          end
        end
      end
      OP_INSERT: begin
        if (item_b_q.has_wildcards) begin
          res.status = ST_WILD;
        end else if (!v0 || eq0) begin
          w0         = 1'b1;
          res.status = ST_OK;
          if (!v0) begin
            cnt_d = cnt_q + CW'(1);
          end
        end else if (!v1 || eq1) begin
          w1            = 1'b1;
          res.status    = ST_OK;
          res.hit_table = 1'b1;
          if (!v1) begin
            cnt_d = cnt_q + CW'(1);
          end
        end else begin
          res.status = ST_FULL;
        end
      end
      OP_DELETE: begin
        if (item_b_q.has_wildcards) begin
          res.status = ST_WILD;
        end else begin
          nd0 = '0;
          nd1 = '0;
          w0  = h0;
          w1  = h1;
          if (h0 && cnt_d != '0) begin
            cnt_d = cnt_d - CW'(1);
          end
          if (h1 && cnt_d != '0) begin
            cnt_d = cnt_d - CW'(1);
          end
          res.deleted_count = {1'b0, h0} + {1'b0, h1};
          res.status        = (h0 | h1) ? ST_OK : ST_MISS;
        end
      end
      default: ;
    endcase
    res.flow_total = TOTAL_W'(cnt_d);
  end

  assign we0 = clr_q | (en & vld_b_q & w0);
  assign we1 = clr_q | (en & vld_b_q & w1);
  assign wa0 = clr_q ? clr_addr_q : addr0_b_q;
  assign wa1 = clr_q ? clr_addr_q : addr1_b_q;
  assign wd0 = clr_q ? '0 : nd0;
  assign wd1 = clr_q ? '0 : nd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (en && vld_b_q) begin
      cnt_q <= cnt_d;
    end
  end

  // output queue
  result_t fq_q [2];
  logic    fq_wp_q, fq_rp_q, push, pop;

  assign push = en & vld_b_q;
  assign pop  = out_valid_o & out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fq_cnt_q <= '0;
      fq_wp_q  <= 1'b0;
      fq_rp_q  <= 1'b0;
    end else begin
      if (push) begin
        fq_wp_q <= ~fq_wp_q;
      end
      if (pop) begin
        fq_rp_q <= ~fq_rp_q;
      end
      fq_cnt_q <= fq_cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fq_q[fq_wp_q] <= res;
    end
  end

  assign out_valid_o     = (fq_cnt_q != 2'd0);
  assign status_o        = fq_q[fq_rp_q].status;
  assign hit_table_o     = fq_q[fq_rp_q].hit_table;
  assign found_handle_o  = fq_q[fq_rp_q].found_handle;
  assign deleted_count_o = fq_q[fq_rp_q].deleted_count;
  assign flow_total_o    = fq_q[fq_rp_q].flow_total;

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps
// Testbench for two_way_hashed_exact_match_table_core: random and directed table
// operations checked against a built-in predictor. Depends on thmt_pkg.
module testbench;
  import thmt_pkg::*;

  typedef struct {
    status_e     status;
    logic        hit_table;
    logic [15:0] found_handle;
    logic [1:0]  deleted_count;
    logic [11:0] flow_total;
  } flow_result_t;

  class flow_scoreboard;
    logic [31:0] poly[2];
    logic [3:0]  lg[2];
    bit          vld[2][1024];
    logic [63:0] keys[2][1024];
    logic [15:0] handles[2][1024];
    int unsigned entries;
    flow_result_t pending[$];
    int mismatches;
    int checked;

    function new();
      poly[0] = POLY0_RESET;
      poly[1] = POLY1_RESET;
      lg[0] = LG_RESET;
      lg[1] = LG_RESET;
      entries = 0;
      mismatches = 0;
      checked = 0;
      foreach (vld[s, b]) vld[s][b] = 0;
    endfunction

    function automatic logic [9:0] bucket(logic [63:0] key, int s);
      logic [31:0] crc;
      logic        top;
      logic [3:0]  l;
      crc = '0;
      for (int i = 63; i >= 0; i--) begin
        top = crc[31] ^ key[i];
        crc = crc << 1;
        if (top) crc = crc ^ poly[s];
      end
      l = (lg[s] > 4'd10) ? 4'd10 : lg[s];
      return crc[9:0] & ((10'd1 << l) - 10'd1);
    endfunction

    function automatic void note_word(logic [1:0] op, logic [63:0] key, logic wild,
                                      logic [15:0] handle);
      flow_result_t r;
      logic [9:0] b;
      r.status = ST_MISS;
      r.hit_table = 0;
      r.found_handle = 0;
      r.deleted_count = 0;
      if (op == OP_LOOKUP) begin
        if (!wild) begin
          for (int s = 0; s < 2; s++) begin
            b = bucket(key, s);
            if (vld[s][b] && keys[s][b] == key) begin
              r.status = ST_OK;
              r.hit_table = s[0];
              r.found_handle = handles[s][b];
              break;
            end
          end
        end
      end else if (op == OP_INSERT) begin
        if (wild) r.status = ST_WILD;
        else begin
          r.status = ST_FULL;
          for (int s = 0; s < 2; s++) begin
            b = bucket(key, s);
            if (!vld[s][b] || keys[s][b] == key) begin
              if (!vld[s][b]) entries++;
              vld[s][b] = 1;
              keys[s][b] = key;
              handles[s][b] = handle;
              r.status = ST_OK;
              r.hit_table = s[0];
              break;
            end
          end
        end
      end else if (op == OP_DELETE) begin
        if (wild) r.status = ST_WILD;
        else begin
          for (int s = 0; s < 2; s++) begin
            b = bucket(key, s);
            if (vld[s][b] && keys[s][b] == key) begin
              vld[s][b] = 0;
              r.deleted_count++;
              if (entries > 0) entries--;
            end
          end
          r.status = r.deleted_count != 0 ? ST_OK : ST_MISS;
        end
      end
      r.flow_total = entries[11:0];
      pending.push_back(r);
    endfunction

    function automatic void check_word(flow_result_t got);
      flow_result_t e;
      checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word at %0t", $realtime);
        return;
      end
      e = pending.pop_front();
      if (got.status != e.status || got.hit_table != e.hit_table ||
          got.found_handle != e.found_handle || got.deleted_count != e.deleted_count ||
          got.flow_total != e.flow_total) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch at %0t: exp st=%0d tb=%0d h=%h del=%0d n=%0d got st=%0d tb=%0d h=%h del=%0d n=%0d",
                   $realtime, e.status, e.hit_table, e.found_handle, e.deleted_count,
                   e.flow_total, got.status, got.hit_table, got.found_handle,
                   got.deleted_count, got.flow_total);
      end
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic in_valid_i = 0;
  logic in_ready_o;
  logic [1:0] op_i = 0;
  logic [63:0] flow_key_i = 0;
  logic has_wildcards_i = 0;
  logic [15:0] flow_handle_i = 0;
  logic out_valid_o;
  logic out_ready_i = 0;
  logic [1:0] status_o;
  logic hit_table_o;
  logic [15:0] found_handle_o;
  logic [1:0] deleted_count_o;
  logic [11:0] flow_total_o;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [3:0] paddr = 0;
  logic [31:0] pwdata = 0;
  logic [31:0] prdata;
  logic pready;

  flow_scoreboard flows = new();
  bit calm;
  logic [63:0] key_pool[$];

  two_way_hashed_exact_match_table_core uut (.*);

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #50ms;
    $display("testbench: errors");
    $finish;
  end

  always @(posedge clk_i) begin
    flow_result_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.status = status_e'(status_o);
      got.hit_table = hit_table_o;
      got.found_handle = found_handle_o;
      got.deleted_count = deleted_count_o;
      got.flow_total = flow_total_o;
      flows.check_word(got);
    end
  end

  // receiver: random stall bursts
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!calm && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 12);
        out_ready_i <= 0;
        repeat (n) @(posedge clk_i);
      end
      out_ready_i <= 1;
    end
  end

  task automatic send_word(logic [1:0] op, logic [63:0] key, logic wild, logic [15:0] h);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    in_valid_i <= 1;
    op_i <= op;
    flow_key_i <= key;
    has_wildcards_i <= wild;
    flow_handle_i <= h;
    do @(posedge clk_i); while (!in_ready_o);
    flows.note_word(op, key, wild, h);
  endtask

  task automatic drain();
    in_valid_i <= 0;
    while (flows.pending.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_e r, logic [31:0] v);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= {r, 2'b00};
    pwdata <= v;
    @(posedge clk_i);
    penable <= 1;
    do @(posedge clk_i); while (!pready);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    case (r)
      REG_POLY0: flows.poly[0] = v;
      REG_POLY1: flows.poly[1] = v;
      REG_LG0: flows.lg[0] = v[3:0];
      default: flows.lg[1] = v[3:0];
    endcase
  endtask

  function automatic logic [63:0] pick_key();
    if (key_pool.size() != 0 && $urandom_range(0, 2) != 0)
      return key_pool[$urandom_range(0, key_pool.size() - 1)];
    return {$urandom, $urandom};
  endfunction

  task automatic random_phase(int count, int pool_size);
    logic [1:0] op;
    int r;
    key_pool.delete();
    repeat (pool_size) key_pool.push_back({$urandom, $urandom});
    repeat (count) begin
      r = $urandom_range(0, 99);
      op = r < 40 ? OP_INSERT : r < 75 ? OP_LOOKUP : r < 97 ? OP_DELETE : 2'd3;
      send_word(op, pick_key(), $urandom_range(0, 19) == 0, $urandom);
    end
    drain();
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1;

    send_word(OP_LOOKUP, 64'h0, 0, 16'h0);
    send_word(OP_INSERT, 64'h0, 0, 16'hFFFF);
    send_word(OP_LOOKUP, 64'h0, 0, 16'h0);
    send_word(OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 0, 16'h0001);
    send_word(OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 0, 16'hA5A5);
    send_word(OP_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 0, 16'h0);
    send_word(OP_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 1, 16'h0);
    send_word(OP_INSERT, 64'h1234, 1, 16'h1);
    send_word(OP_DELETE, 64'h0, 1, 16'h0);
    send_word(2'd3, 64'h0, 0, 16'h0);
    send_word(OP_DELETE, 64'h0, 0, 16'h0);
    send_word(OP_DELETE, 64'h0, 0, 16'h0);
    send_word(OP_LOOKUP, 64'h0, 0, 16'h0);
    drain();

    // one bucket per subtable: collisions, then a key in both after a delete
    write_reg(REG_LG0, 4'd0);
    write_reg(REG_LG1, 4'd0);
    send_word(OP_INSERT, 64'h11, 0, 16'h0011);
    send_word(OP_INSERT, 64'h22, 0, 16'h0022);
    send_word(OP_INSERT, 64'h33, 0, 16'h0033);
    send_word(OP_DELETE, 64'h11, 0, 16'h0);
    send_word(OP_INSERT, 64'h22, 0, 16'h0044);
    send_word(OP_LOOKUP, 64'h22, 0, 16'h0);
    send_word(OP_DELETE, 64'h22, 0, 16'h0);
    send_word(OP_LOOKUP, 64'h22, 0, 16'h0);
    drain();
    random_phase(200, 6);

    write_reg(REG_POLY0, 32'h0);
    write_reg(REG_POLY1, 32'hFFFF_FFFF);
    write_reg(REG_LG0, 4'd15);
    write_reg(REG_LG1, 4'd3);
    random_phase(400, 40);

    write_reg(REG_POLY0, $urandom);
    write_reg(REG_POLY1, $urandom);
    write_reg(REG_LG0, 4'd2);
    write_reg(REG_LG1, 4'd10);
    random_phase(400, 60);

    write_reg(REG_POLY0, POLY0_RESET);
    write_reg(REG_POLY1, POLY1_RESET);
    write_reg(REG_LG0, 4'd11);
    write_reg(REG_LG1, 4'd1);
    random_phase(450, 100);

    calm = 1;
    random_phase(300, 50);

    $display("covered %0d result words over five register settings", flows.checked);
    $display("final table population %0d entries", flows.entries);
    if (flows.mismatches == 0 && flows.pending.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("%0d mismatches", flows.mismatches);
      $display("testbench: errors");
    end
    $finish;
  end
endmodule

[two_way_hashed_exact_match_table_core.f]
sv/thmt_pkg.sv
sv/thmt_hash_pipe.sv
sv/two_way_hashed_exact_match_table_core.sv
test/testbench.sv
